/* hdl/ddwr_pkg.sv */
// ----------------------------------------------------------------------------
// ddwr_pkg
// Shared types and constants for the deck dealer: payload structs, opcodes,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ddwr_pkg;

	// Default deck capacity and the deck size loaded at reset
	localparam int MAX_CARDS_DEF = 64;
	localparam int DECK_RESET    = 52;

	// Operation codes
	localparam logic [1:0] OP_RELOAD = 2'd0;
	localparam logic [1:0] OP_DEAL   = 2'd1;
	localparam logic [1:0] OP_OMIT   = 2'd2;

	// Input beat
	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] pick;
		logic [6:0] card_value;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic [6:0] card;
		logic       found;
		logic [6:0] remaining;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic deal_ok;
		logic match;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

/* hdl/ddwr_controller.sv */
// ----------------------------------------------------------------------------
// ddwr_controller
// Sequencer for one operation at a time: capture, range check, bit scan for
// a deal, then commit into the result register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_controller (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire ddwr_pkg::ctrl_stat_t  stat,
	output ddwr_pkg::ctrl_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Decode commands from the current state
	always_comb begin
		item_ready  = (state_q == ST_IDLE);
		cmd.capture = (state_q == ST_IDLE) && item_valid;
		cmd.scan    = (state_q == ST_SCAN);
		cmd.commit  = (state_q == ST_FIN) && stat.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.deal_ok ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				if (stat.match) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/ddwr_datapath.sv */
// ----------------------------------------------------------------------------
// ddwr_datapath
// Presence map, remaining count, deck size register, scan pointer and the
// result register. Works under commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_datapath #(
	parameter int MAX_CARDS = ddwr_pkg::MAX_CARDS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [6:0]            cfg_wdata,
	input  wire ddwr_pkg::in_item_t    item,
	input  wire ddwr_pkg::ctrl_cmd_t   cmd,
	output ddwr_pkg::ctrl_stat_t       stat,
	input  wire logic                  result_ready,
	output logic                       result_valid,
	output ddwr_pkg::out_item_t        result
);

	localparam int IdxW       = $clog2(MAX_CARDS);
	localparam int CntW       = $clog2(MAX_CARDS + 1);
	localparam int CmpPW      = (CntW > 6) ? CntW : 6;
	localparam int CmpDW      = (CntW > 7) ? CntW : 7;
	localparam int ResetCards = (ddwr_pkg::DECK_RESET < MAX_CARDS) ?
		ddwr_pkg::DECK_RESET : MAX_CARDS;

	logic [6:0]           deck_size_q;
	logic [MAX_CARDS-1:0] present_q;
	logic [CntW-1:0]      count_q;
	logic [1:0]           op_q;
	logic [5:0]           pick_q;
	logic [6:0]           value_q;
	logic [IdxW-1:0]      idx_q;
	logic [5:0]           seen_q;
	logic                 hit_q;
	logic                 out_valid_q;
	ddwr_pkg::out_item_t  out_q;

	logic                 bit_here;
	logic                 match;
	logic [MAX_CARDS-1:0] reload_map;
	logic [CntW-1:0]      reload_cnt;
	logic [7:0]           value_m1;
	logic [IdxW-1:0]      omit_idx;
	logic                 omit_hit;
	logic [IdxW:0]        card_w;
	logic [MAX_CARDS-1:0] map_n;
	logic [CntW-1:0]      cnt_n;
	logic [6:0]           card_n;
	logic                 found_n;

	// Scan probe: current bit and whether it is the picked position
	assign bit_here = present_q[idx_q];
	assign match    = bit_here && (seen_q == pick_q);

	// Status back to the controller
	always_comb begin
		stat.deal_ok  = (op_q == ddwr_pkg::OP_DEAL) &&
			(CmpPW'(pick_q) < CmpPW'(count_q));
		stat.match    = match;
		stat.out_free = !out_valid_q || result_ready;
	end

	// Full deck image for a reload, clamped to capacity
	always_comb begin
		for (int i = 0; i < MAX_CARDS; i++) begin
			reload_map[i] = (i < int'(deck_size_q));
		end
		if (CmpDW'(deck_size_q) > CmpDW'(MAX_CARDS)) begin
			reload_cnt = CntW'(MAX_CARDS);
		end else begin
			reload_cnt = CntW'(deck_size_q);
		end
	end

	// Omit lookup
	assign value_m1 = {1'b0, value_q} - 8'd1;
	assign omit_idx = IdxW'(value_m1);
	assign omit_hit = (value_q != 7'd0) && (int'(value_q) <= MAX_CARDS) &&
		present_q[omit_idx];

	// Card number of the scan hit
	assign card_w = {1'b0, idx_q} + {{IdxW{1'b0}}, 1'b1};

	// Next map, count and result for the operation being committed
	always_comb begin
		map_n   = present_q;
		cnt_n   = count_q;
		card_n  = 7'd0;
		found_n = 1'b0;
		case (op_q)
			ddwr_pkg::OP_RELOAD: begin
				map_n = reload_map;
				cnt_n = reload_cnt;
			end
			ddwr_pkg::OP_DEAL: begin
				if (hit_q) begin
					map_n[idx_q] = 1'b0;
					cnt_n        = count_q - {{(CntW-1){1'b0}}, 1'b1};
					card_n       = 7'(card_w);
					found_n      = 1'b1;
				end
			end
			ddwr_pkg::OP_OMIT: begin
				if (omit_hit) begin
					map_n[omit_idx] = 1'b0;
					cnt_n           = count_q - {{(CntW-1){1'b0}}, 1'b1};
					found_n         = 1'b1;
				end
			end
			default: begin
				map_n = present_q;
			end
		endcase
	end

	// Deck size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_size_q <= 7'(ddwr_pkg::DECK_RESET);
		end else if (cfg_wen) begin
			deck_size_q <= cfg_wdata;
		end
	end

	// Deck state: update on commit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CARDS; i++) begin
				present_q[i] <= (i < ResetCards);
			end
			count_q <= CntW'(ResetCards);
		end else if (cmd.commit) begin
			present_q <= map_n;
			count_q   <= cnt_n;
		end
	end

	// Hold the captured beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= item.opcode;
			pick_q  <= item.pick;
			value_q <= item.card_value;
		end
	end

	// Scan pointer: start at the largest card, step down one bit a cycle until the pick matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			seen_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.capture) begin
			idx_q  <= IdxW'(MAX_CARDS - 1);
			seen_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.scan) begin
			if (match) begin
				hit_q <= 1'b1;
			end else begin
				if (bit_here) seen_q <= seen_q + 6'd1;
				idx_q <= idx_q - {{(IdxW-1){1'b0}}, 1'b1};
			end
		end
	end

	// Result register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.card      <= card_n;
			out_q.found     <= found_n;
			out_q.remaining <= 7'(cnt_n);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

/* hdl/deck_deal_without_replacement_top.sv */
// ----------------------------------------------------------------------------
// deck_deal_without_replacement_top
// Draw without replacement from cards 1..deck_size: reload, deal at a pick
// position counted from the largest remaining card, or omit a named card.
//
//   Channel   Signals                        Dir   Content
//   item      item_valid/item_ready/item     in    opcode, pick, card_value
//   result    result_valid/result_ready/...  out   card, found, remaining
//   cfg       cfg_wen/cfg_wdata              in    deck_size, no wait
//
// One operation at a time. A deal runs a presence-map scan that tests one
// bit per cycle from the top, and its result waits for that scan; reload,
// omit and no-op go from accept through the check to commit with no scan.
// An out-of-range pick skips the scan. Reset loads 52 cards (or MAX_CARDS).
// The result register holds a finished beat while the next item is taken;
// commit of that item waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module deck_deal_without_replacement_top #(
	parameter int MAX_CARDS = ddwr_pkg::MAX_CARDS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wen,
	input  wire logic [6:0]          cfg_wdata,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire ddwr_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output ddwr_pkg::out_item_t      result
);

	ddwr_pkg::ctrl_cmd_t  cmd;
	ddwr_pkg::ctrl_stat_t stat;

	ddwr_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	ddwr_datapath #(
		.MAX_CARDS (MAX_CARDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

/* hdl/ddwr_checker.sv */
// ----------------------------------------------------------------------------
// ddwr_checker
// Port-level checks on the deck dealer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire ddwr_pkg::out_item_t result
);

	// A stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// One operation in flight: no accept on the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while busy");

	// A nonzero card is always a successful deal
	a_card_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.card != 7'd0) |-> result.found)
		else $error("card reported without found");

	// Idle with nothing offered: no result beat shows up
	a_no_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && item_ready && !item_valid |=> !result_valid)
		else $error("result appeared without an item");

endmodule

bind deck_deal_without_replacement_top ddwr_checker u_ddwr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
